// ===== src/rcit_pkg.sv =====
// ----------------------------------------------------------------------------
// rcit_pkg
// shared codes, widths and cell control type for the ref-counted tag table
// ----------------------------------------------------------------------------
package rcit_pkg;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam int ACT_W = 2;
    localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CREATE  = 2'd2;

    localparam int STAT_W = 3;
    localparam logic [STAT_W-1:0] STAT_HIT       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EVICTED   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_RELEASED  = 3'd4;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd5;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 3'd6;

    // per-cell control for one cycle
    typedef struct packed {
        logic cmp;        // capture match / zero-users flags
        logic load_new;   // head cell takes the new entry
        logic ins_free;   // insert into free space: shift while neighbor valid
        logic ins_evict;  // insert over victim: shift at or above victim
        logic inc;        // saturating increment of the hit cell
        logic dec;        // decrement of the hit cell
    } t_cell_ctl;

endpackage

// ===== src/rcit_req_if.sv =====
// ----------------------------------------------------------------------------
// rcit_req_if
// request channel: action and object index with valid/ready
// ----------------------------------------------------------------------------
interface rcit_req_if #(
    parameter int INDEX_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            action;
    logic [INDEX_BITS-1:0] object_index;

    modport source (output valid, action, object_index, input ready);
    modport sink   (input valid, action, object_index, output ready);
endinterface

// ===== src/rcit_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rcit_rsp_if
// response channel: status, eviction report and resulting user count
// ----------------------------------------------------------------------------
interface rcit_rsp_if #(
    parameter int INDEX_BITS = 16,
    parameter int COUNT_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            status;
    logic                  evicted_valid;
    logic [INDEX_BITS-1:0] evicted_index;
    logic [COUNT_BITS-1:0] users_after;

    modport source (output valid, status, evicted_valid, evicted_index, users_after,
                    input ready);
    modport sink   (input valid, status, evicted_valid, evicted_index, users_after,
                    output ready);
endinterface

// ===== src/refcounted_inode_cache_table_core.sv =====
// ----------------------------------------------------------------------------
// refcounted_inode_cache_table_core
// fully associative table of object indices with per-entry user counts
// ----------------------------------------------------------------------------
// The table is a chain of ENTRIES cells kept in insertion order: cell 0
// holds the newest entry and valid entries are always packed at the head.
// A load looks the index up and bumps the count of the newest match, or
// inserts it with one user; a create inserts with zero users; a release
// drops the count of the newest match. An insert shifts the chain down one
// cell and enters at the head, into free space while occupancy is below the
// capacity limit, otherwise over the oldest entry with no users (reported
// as evicted); with no such entry it is dropped as full. Each transaction
// runs through a compare state, in which every cell compares its index and
// flags an unused entry, and a resolve state, in which the priority chains
// ripple through all cells, the chain updates and the response is registered.
// The next request is taken in the resolve state as the previous one
// completes; a response held by the sink stalls the resolve state.
// capacity_limit (byte address 0) is applied in the resolve state of each request;
// 0 behaves as 1 and values above ENTRIES behave as ENTRIES.
// ----------------------------------------------------------------------------
module refcounted_inode_cache_table_core
    import rcit_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int INDEX_BITS = 16,
    parameter int COUNT_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // transaction channels
    rcit_req_if.sink    i_req,
    rcit_rsp_if.source  o_rsp
);

    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int LIM_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [CAP_W-1:0]      r_cap;
    logic [OCC_W-1:0]      r_occ, n_occ;
    logic [1:0]            r_action;
    logic [INDEX_BITS-1:0] r_object;

    // registered response
    logic                  r_out_valid;
    logic [2:0]            r_status, n_status;
    logic                  r_evicted_valid, n_evicted_valid;
    logic [INDEX_BITS-1:0] r_evicted_index, n_evicted_index;
    logic [COUNT_BITS-1:0] r_users_after, n_users_after;

    // chain wiring; the search chains get one extra slot for the chain ends
    logic                  c_valid  [ENTRIES];
    logic [INDEX_BITS-1:0] c_object [ENTRIES];
    logic [COUNT_BITS-1:0] c_users  [ENTRIES];
    logic                  seen     [ENTRIES+1];
    logic [COUNT_BITS-1:0] hit_acc  [ENTRIES+1];
    logic [INDEX_BITS-1:0] vic_acc  [ENTRIES+1];
    logic                  later    [ENTRIES+1];
    logic                  vic_lat  [ENTRIES+1];

    t_cell_ctl             ctl_body;
    t_cell_ctl             ctl_head;
    logic [COUNT_BITS-1:0] new_users;
    logic                  exec_fire;
    logic                  req_fire;
    logic                  cfg_write;
    logic [LIM_W-1:0]      cap_ext;
    logic [LIM_W-1:0]      eff_limit;
    logic                  has_room;
    logic                  any_match;
    logic                  any_zero;
    logic [COUNT_BITS-1:0] hit_users;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {{(32-CAP_W){1'b0}}, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_write) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    // clamp the limit into 1..ENTRIES
    always_comb begin
        cap_ext = LIM_W'(r_cap);
        if (cap_ext == '0) begin
            eff_limit = LIM_W'(1);
        end else if (cap_ext > LIM_W'(ENTRIES)) begin
            eff_limit = LIM_W'(ENTRIES);
        end else begin
            eff_limit = cap_ext;
        end
    end
    assign has_room = LIM_W'(r_occ) < eff_limit;

    // ---------------- handshake ----------------
    // the resolve cycle completes once the response register is free
    assign exec_fire   = (r_state == ST_EXEC) & (~r_out_valid | o_rsp.ready);
    assign i_req.ready = (r_state == ST_IDLE) | exec_fire;
    assign req_fire    = i_req.valid & i_req.ready;

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_action <= i_req.action;
            r_object <= i_req.object_index;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    n_state = req_fire ? ST_CMP : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------- cell chain ----------------
    assign seen[0]          = 1'b0;
    assign hit_acc[0]       = '0;
    assign vic_acc[0]       = '0;
    assign later[ENTRIES]   = 1'b0;
    assign vic_lat[ENTRIES] = 1'b0;

    assign any_match = seen[ENTRIES];
    assign any_zero  = later[0];
    assign hit_users = hit_acc[ENTRIES];
    assign new_users = (r_action == ACT_LOAD) ? COUNT_BITS'(1) : '0;

    // per-transaction decision in the resolve cycle
    always_comb begin
        ctl_body        = '0;
        ctl_body.cmp    = (r_state == ST_CMP);
        n_occ           = r_occ;
        n_status        = STAT_NOT_FOUND;
        n_evicted_valid = 1'b0;
        n_evicted_index = '0;
        n_users_after   = '0;
        if (r_action == ACT_LOAD && any_match) begin
            // hit, count saturates
            ctl_body.inc  = 1'b1;
            n_status      = STAT_HIT;
            n_users_after = (hit_users == '1) ? hit_users : hit_users + COUNT_BITS'(1);
        end else if (r_action == ACT_LOAD || r_action == ACT_CREATE) begin
            // insert path
            n_users_after = new_users;
            if (has_room) begin
                ctl_body.ins_free = 1'b1;
                n_occ             = r_occ + OCC_W'(1);
                n_status          = STAT_INSERTED;
            end else if (any_zero) begin
                ctl_body.ins_evict = 1'b1;
                n_status           = STAT_EVICTED;
                n_evicted_valid    = 1'b1;
                n_evicted_index    = vic_acc[ENTRIES];
            end else begin
                n_status      = STAT_FULL;
                n_users_after = '0;
            end
        end else if (r_action == ACT_RELEASE && any_match) begin
            if (hit_users == '0) begin
                n_status = STAT_UNDERFLOW;
            end else begin
                ctl_body.dec  = 1'b1;
                n_status      = STAT_RELEASED;
                n_users_after = hit_users - COUNT_BITS'(1);
            end
        end
        // updates only land on the completing edge
        if (!exec_fire) begin
            ctl_body.inc       = 1'b0;
            ctl_body.dec       = 1'b0;
            ctl_body.ins_free  = 1'b0;
            ctl_body.ins_evict = 1'b0;
        end
        ctl_head          = ctl_body;
        ctl_head.load_new = ctl_body.ins_free | ctl_body.ins_evict;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic                  prev_valid;
        logic [INDEX_BITS-1:0] prev_object;
        logic [COUNT_BITS-1:0] prev_users;

        if (g == 0) begin : g_head
            assign prev_valid  = 1'b0;
            assign prev_object = '0;
            assign prev_users  = '0;
        end else begin : g_body
            assign prev_valid  = c_valid[g-1];
            assign prev_object = c_object[g-1];
            assign prev_users  = c_users[g-1];
        end

        rcit_cell #(
            .INDEX_BITS (INDEX_BITS),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         ((g == 0) ? ctl_head : ctl_body),
            .i_req_object  (r_object),
            .i_new_users   (new_users),
            .i_prev_valid  (prev_valid),
            .i_prev_object (prev_object),
            .i_prev_users  (prev_users),
            .i_seen_match  (seen[g]),
            .i_hit_users   (hit_acc[g]),
            .i_vic_object  (vic_acc[g]),
            .i_later_zero  (later[g+1]),
            .i_vic_later   (vic_lat[g+1]),
            .o_valid       (c_valid[g]),
            .o_object      (c_object[g]),
            .o_users       (c_users[g]),
            .o_seen_match  (seen[g+1]),
            .o_hit_users   (hit_acc[g+1]),
            .o_vic_object  (vic_acc[g+1]),
            .o_later_zero  (later[g]),
            .o_vic_later   (vic_lat[g])
        );
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_fire) begin
                r_occ       <= n_occ;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_status        <= n_status;
            r_evicted_valid <= n_evicted_valid;
            r_evicted_index <= n_evicted_index;
            r_users_after   <= n_users_after;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.evicted_valid = r_evicted_valid;
    assign o_rsp.evicted_index = r_evicted_index;
    assign o_rsp.users_after   = r_users_after;

endmodule

// ===== src/rcit_cell.sv =====
// ----------------------------------------------------------------------------
// rcit_cell
// one table entry of the age-ordered chain with its search chain segments
// ----------------------------------------------------------------------------
module rcit_cell
    import rcit_pkg::*;
#(
    parameter int INDEX_BITS = 16,
    parameter int COUNT_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [INDEX_BITS-1:0] i_req_object,
    input  logic [COUNT_BITS-1:0] i_new_users,
    // entry of the younger neighbor
    input  logic                  i_prev_valid,
    input  logic [INDEX_BITS-1:0] i_prev_object,
    input  logic [COUNT_BITS-1:0] i_prev_users,
    // chains running from the head (younger side)
    input  logic                  i_seen_match,
    input  logic [COUNT_BITS-1:0] i_hit_users,
    input  logic [INDEX_BITS-1:0] i_vic_object,
    // chains running from the tail (older side)
    input  logic                  i_later_zero,
    input  logic                  i_vic_later,
    output logic                  o_valid,
    output logic [INDEX_BITS-1:0] o_object,
    output logic [COUNT_BITS-1:0] o_users,
    output logic                  o_seen_match,
    output logic [COUNT_BITS-1:0] o_hit_users,
    output logic [INDEX_BITS-1:0] o_vic_object,
    output logic                  o_later_zero,
    output logic                  o_vic_later
);

    logic                  r_valid;
    logic [INDEX_BITS-1:0] r_object;
    logic [COUNT_BITS-1:0] r_users;
    logic                  r_match;
    logic                  r_zero;

    logic hit;
    logic victim;
    logic vic_here_or_older;
    logic take_prev;

    // newest match: nothing matched toward the head
    assign hit    = r_match & ~i_seen_match;
    // oldest unused: nothing unused toward the tail
    assign victim = r_zero & ~i_later_zero;
    assign vic_here_or_older = victim | i_vic_later;

    assign take_prev = (i_ctl.ins_free & i_prev_valid) | (i_ctl.ins_evict & vic_here_or_older);

    assign o_seen_match = i_seen_match | r_match;
    assign o_later_zero = i_later_zero | r_zero;
    assign o_vic_later  = vic_here_or_older;
    assign o_hit_users  = i_hit_users | (hit ? r_users : '0);
    assign o_vic_object = i_vic_object | (victim ? r_object : '0);

    assign o_valid  = r_valid;
    assign o_object = r_object;
    assign o_users  = r_users;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load_new) begin
            r_valid <= 1'b1;
        end else if (take_prev) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_match <= r_valid & (r_object == i_req_object);
            r_zero  <= r_valid & (r_users == '0);
        end
        if (i_ctl.load_new) begin
            r_object <= i_req_object;
            r_users  <= i_new_users;
        end else if (take_prev) begin
            r_object <= i_prev_object;
            r_users  <= i_prev_users;
        end else if (i_ctl.inc && hit && r_users != '1) begin
            r_users <= r_users + COUNT_BITS'(1);
        end else if (i_ctl.dec && hit) begin
            r_users <= r_users - COUNT_BITS'(1);
        end
    end

endmodule

// ===== bench/refcounted_inode_cache_table_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// refcounted_inode_cache_table_core_tb
// self-checking bench for the ref-counted tag table: a directed table of
// requests with limit changes, a count saturation run, then random phases
// under several capacity limits, every response checked against a typed-in result or the predictor
// ----------------------------------------------------------------------------
module refcounted_inode_cache_table_core_tb;
    import rcit_pkg::*;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = 16;
    localparam int CNT_W   = 8;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [2:0]       CAP_ADDR   = 3'd0;
    localparam logic [CNT_W-1:0] CNT_MAX    = '1;

    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 210;
    localparam int POOL_MAX     = 24;
    localparam int SAT_LOADS    = 258;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 40;

    // one response of the table, in port order
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              evicted_valid;
        logic [IDX_W-1:0]  evicted_index;
        logic [CNT_W-1:0]  users_after;
    } t_table_result;

    // directed rows: predicted, typed-in result, or a capacity change
    typedef enum logic [1:0] {ROW_PREDICT, ROW_FIXED, ROW_LIMIT} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [ACT_W-1:0] act;
        logic [IDX_W-1:0] obj;
        logic [CAP_W-1:0] limit;
        t_table_result    want;
    } t_dir_row;

    typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} t_sink_mode;

    localparam t_table_result UNTYPED = '0;
    localparam int NUM_DIR = 23;

    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        // empty table: release misses, unused action reports not found
        '{ROW_FIXED,   ACT_RELEASE, 16'h0000, 5'd0, '{STAT_NOT_FOUND, 1'b0, 16'h0, 8'd0}},
        '{ROW_FIXED,   ACT_UNUSED,  16'hFFFF, 5'd0, '{STAT_NOT_FOUND, 1'b0, 16'h0, 8'd0}},
        // load miss inserts with one user, then a hit
        '{ROW_FIXED,   ACT_LOAD,    16'hFFFF, 5'd0, '{STAT_INSERTED,  1'b0, 16'h0, 8'd1}},
        '{ROW_FIXED,   ACT_LOAD,    16'hFFFF, 5'd0, '{STAT_HIT,       1'b0, 16'h0, 8'd2}},
        // create with zero users, release of it underflows
        '{ROW_FIXED,   ACT_CREATE,  16'h0000, 5'd0, '{STAT_INSERTED,  1'b0, 16'h0, 8'd0}},
        '{ROW_FIXED,   ACT_RELEASE, 16'h0000, 5'd0, '{STAT_UNDERFLOW, 1'b0, 16'h0, 8'd0}},
        // duplicate create, then lookups land on the newest copy
        '{ROW_PREDICT, ACT_CREATE,  16'h0000, 5'd0, UNTYPED},
        '{ROW_PREDICT, ACT_LOAD,    16'h0000, 5'd0, UNTYPED},
        '{ROW_PREDICT, ACT_RELEASE, 16'h0000, 5'd0, UNTYPED},
        '{ROW_PREDICT, ACT_RELEASE, 16'h0000, 5'd0, UNTYPED},
        // limit dropped below occupancy: inserts evict the oldest unused
        '{ROW_LIMIT,   ACT_LOAD,    16'h0000, 5'd2, UNTYPED},
        '{ROW_PREDICT, ACT_LOAD,    16'h1234, 5'd0, UNTYPED},
        '{ROW_PREDICT, ACT_CREATE,  16'hA5A5, 5'd0, UNTYPED},
        '{ROW_PREDICT, ACT_LOAD,    16'hA5A5, 5'd0, UNTYPED},
        // every entry in use: insert dropped as full
        '{ROW_PREDICT, ACT_CREATE,  16'h5A5A, 5'd0, UNTYPED},
        // zero limit behaves as one
        '{ROW_LIMIT,   ACT_LOAD,    16'h0000, 5'd0, UNTYPED},
        '{ROW_PREDICT, ACT_CREATE,  16'h0001, 5'd0, UNTYPED},
        // limit above the table size behaves as the table size
        '{ROW_LIMIT,   ACT_LOAD,    16'h0000, 5'd31, UNTYPED},
        '{ROW_PREDICT, ACT_CREATE,  16'h0001, 5'd0, UNTYPED},
        '{ROW_PREDICT, ACT_RELEASE, 16'hFFFF, 5'd0, UNTYPED},
        '{ROW_PREDICT, ACT_RELEASE, 16'hFFFF, 5'd0, UNTYPED},
        '{ROW_PREDICT, ACT_RELEASE, 16'hFFFF, 5'd0, UNTYPED},
        '{ROW_PREDICT, ACT_UNUSED,  16'h0000, 5'd0, UNTYPED}
    };

    localparam logic [CAP_W-1:0] PHASE_LIMITS [PHASES] = '{
        5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd9
    };

    // ------------------------------------------------------------------------
    // clock, reset, configuration port and channels
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rcit_req_if #(.INDEX_BITS(IDX_W)) req_ch ();
    rcit_rsp_if #(.INDEX_BITS(IDX_W), .COUNT_BITS(CNT_W)) rsp_ch ();

    always #5 i_clk = ~i_clk;

    refcounted_inode_cache_table_core #(
        .ENTRIES   (ENTRIES),
        .INDEX_BITS(IDX_W),
        .COUNT_BITS(CNT_W)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // ------------------------------------------------------------------------
    // table predictor: slots with insertion ages, age 0 is the newest
    // ------------------------------------------------------------------------
    logic             tbl_valid  [ENTRIES] = '{default: 1'b0};
    logic [IDX_W-1:0] tbl_object [ENTRIES];
    logic [CNT_W-1:0] tbl_users  [ENTRIES];
    int unsigned      tbl_age    [ENTRIES];
    int unsigned      tbl_fill = 0;
    logic [CAP_W-1:0] cap_setting = CAP_RESET;

    t_table_result    expected_q [$];
    int               mismatch_count = 0;
    int               burst_left = 0;

    // newest live slot holding obj, or -1
    function automatic int newest_match(input logic [IDX_W-1:0] obj);
        int hit = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_object[i] == obj &&
                (hit < 0 || tbl_age[i] < tbl_age[hit]))
                hit = i;
        end
        return hit;
    endfunction

    // slot becomes newest; slots younger than its former age (all live slots if it was free) grow older
    function automatic void place_entry(input int slot, input logic [IDX_W-1:0] obj,
                                        input logic [CNT_W-1:0] users);
        logic        was_live = tbl_valid[slot];
        int unsigned prev_age = tbl_age[slot];
        for (int i = 0; i < ENTRIES; i++) begin
            if (i != slot && tbl_valid[i] && (!was_live || tbl_age[i] < prev_age))
                tbl_age[i]++;
        end
        tbl_valid[slot]  = 1'b1;
        tbl_object[slot] = obj;
        tbl_users[slot]  = users;
        tbl_age[slot]    = 0;
    endfunction

    // insert into free space below the limit, else over the oldest unused entry
    function automatic t_table_result insert_entry(input logic [IDX_W-1:0] obj,
                                                   input logic [CNT_W-1:0] users);
        t_table_result res = '0;
        int            victim = -1;
        int unsigned   lim;
        lim = (cap_setting == 0) ? 1 : (cap_setting > ENTRIES) ? ENTRIES : cap_setting;
        if (tbl_fill < lim) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (!tbl_valid[i]) begin
                    place_entry(i, obj, users);
                    tbl_fill++;
                    res.status      = STAT_INSERTED;
                    res.users_after = users;
                    return res;
                end
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_users[i] == 0 &&
                (victim < 0 || tbl_age[i] > tbl_age[victim]))
                victim = i;
        end
        if (victim < 0) begin
            res.status = STAT_FULL;
            return res;
        end
        res.status        = STAT_EVICTED;
        res.evicted_valid = 1'b1;
        res.evicted_index = tbl_object[victim];
        res.users_after   = users;
        place_entry(victim, obj, users);
        return res;
    endfunction

    function automatic t_table_result predict_table_access(input logic [ACT_W-1:0] act,
                                                           input logic [IDX_W-1:0] obj);
        t_table_result res = '0;
        int            slot;
        res.status = STAT_NOT_FOUND;
        case (act)
            ACT_LOAD: begin
                slot = newest_match(obj);
                if (slot >= 0) begin
                    // count saturates at its maximum
                    if (tbl_users[slot] != CNT_MAX)
                        tbl_users[slot]++;
                    res.status      = STAT_HIT;
                    res.users_after = tbl_users[slot];
                end else begin
                    res = insert_entry(obj, CNT_W'(1));
                end
            end
            ACT_RELEASE: begin
                slot = newest_match(obj);
                if (slot >= 0) begin
                    if (tbl_users[slot] == 0) begin
                        res.status = STAT_UNDERFLOW;
                    end else begin
                        tbl_users[slot]--;
                        res.status      = STAT_RELEASED;
                        res.users_after = tbl_users[slot];
                    end
                end
            end
            ACT_CREATE: begin
                res = insert_entry(obj, '0);
            end
            default: begin
                // unused action: table untouched, not found
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // request side: bursts of random length separated by random gaps
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] obj,
                                input logic use_fixed, input t_table_result fixed);
        t_table_result predicted;
        if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        req_ch.valid        <= 1'b1;
        req_ch.action       <= act;
        req_ch.object_index <= obj;
        do
            @(posedge i_clk);
        while (!req_ch.ready);
        // transaction accepted at this edge: predict in acceptance order
        predicted = predict_table_access(act, obj);
        expected_q.push_back(use_fixed ? fixed : predicted);
    endtask

    // stop sending and wait for every outstanding response
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    // capacity write only with the table idle: setup phase, then access phase
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_setting = value;
    endtask

    // ------------------------------------------------------------------------
    // response side: ready pattern switches between open, random and periodic
    // ------------------------------------------------------------------------
    t_sink_mode sink_mode = SINK_OPEN;
    int         sink_left = 0;
    int         sink_tick = 0;
    logic       sink_ready = 1'b0;

    assign rsp_ch.ready = sink_ready;

    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 2));
            sink_left = $urandom_range(16, 160);
        end
        sink_left--;
        sink_tick++;
        case (sink_mode)
            SINK_OPEN:   sink_ready <= 1'b1;
            SINK_RANDOM: sink_ready <= ($urandom_range(0, 2) != 0);
            default:     sink_ready <= ((sink_tick % 5) < 2);
        endcase
    end

    // each accepted response against the oldest expectation, field by field
    always @(posedge i_clk) begin : rsp_monitor
        t_table_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("response with no request outstanding");
            end else begin
                want = expected_q.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              rsp_ch.status, want.status));
                if (rsp_ch.evicted_valid !== want.evicted_valid)
                    report_mismatch($sformatf("evicted_valid got %0b want %0b",
                                              rsp_ch.evicted_valid, want.evicted_valid));
                if (rsp_ch.evicted_index !== want.evicted_index)
                    report_mismatch($sformatf("evicted_index got %h want %h",
                                              rsp_ch.evicted_index, want.evicted_index));
                if (rsp_ch.users_after !== want.users_after)
                    report_mismatch($sformatf("users_after got %0d want %0d",
                                              rsp_ch.users_after, want.users_after));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [IDX_W-1:0] pool [POOL_MAX];
        int               pool_n;
        int               pick;
        logic [ACT_W-1:0] act;
        logic [IDX_W-1:0] obj;
        logic [CAP_W-1:0] lim;

        // every input known from time zero
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.action       <= ACT_LOAD;
        req_ch.object_index <= '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < NUM_DIR; r++) begin
            case (DIR_ROWS[r].kind)
                ROW_LIMIT: write_capacity(DIR_ROWS[r].limit);
                ROW_FIXED: send_request(DIR_ROWS[r].act, DIR_ROWS[r].obj, 1'b1,
                                        DIR_ROWS[r].want);
                default:   send_request(DIR_ROWS[r].act, DIR_ROWS[r].obj, 1'b0, UNTYPED);
            endcase
        end

        // drive one entry's count into saturation, then back off a little
        for (int k = 0; k < SAT_LOADS; k++)
            send_request(ACT_LOAD, 16'h0001, 1'b0, UNTYPED);
        for (int k = 0; k < 3; k++)
            send_request(ACT_RELEASE, 16'h0001, 1'b0, UNTYPED);

        // random phases, each under its own capacity limit and index pool
        for (int p = 0; p < PHASES; p++) begin
            lim = (p == PHASES - 1) ? CAP_W'($urandom_range(0, 31)) : PHASE_LIMITS[p];
            write_capacity(lim);
            // small pools give hits and releases, large ones churn the table
            pool_n = $urandom_range(3, POOL_MAX);
            for (int i = 0; i < POOL_MAX; i++)
                pool[i] = IDX_W'($urandom);
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    act = ACT_LOAD;
                else if (pick < 80)
                    act = ACT_RELEASE;
                else if (pick < 95)
                    act = ACT_CREATE;
                else
                    act = ACT_UNUSED;
                if ($urandom_range(0, 9) == 0)
                    obj = IDX_W'($urandom);
                else
                    obj = pool[$urandom_range(0, pool_n - 1)];
                send_request(act, obj, 1'b0, UNTYPED);
            end
        end

        // all responses in, then idle for a while to catch strays
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin : watchdog
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
